FILE: sv/llhq_pkg.sv
// ----------------------------------------------------------------------------
// llhq_pkg
// Shared types, constants and edge tables of the log-bucketed latency
// histogram with quantile readout.
// ----------------------------------------------------------------------------
`default_nettype none

package llhq_pkg;

  // bucket layout
  localparam int BUCKETS_PER_DECADE = 24;
  localparam int DECADES            = 7;
  localparam int LOW_EXP            = 2;
  localparam int NUM_EDGES          = DECADES * BUCKETS_PER_DECADE + 1;
  localparam int NUM_BUCKETS        = NUM_EDGES + 1;
  localparam int BKT_W              = $clog2(NUM_BUCKETS);
  localparam int EDGE_IDX_W         = $clog2(NUM_EDGES);
  localparam int BIT_CNT_W          = $clog2(BKT_W);

  // exponent steps for the float estimates of edges and midpoints
  localparam real EDGE_STEP = 1.0 / real'(BUCKETS_PER_DECADE);
  localparam real MID_STEP  = 1.0 / real'(2 * BUCKETS_PER_DECADE);

  // field widths
  localparam int SAMPLE_W  = 32;
  localparam int FRAC_W    = 17;
  localparam int FRAC_SH   = FRAC_W - 1;
  localparam int NS_W      = 30;
  localparam int OUT_CNT_W = 32;

  localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_SH{1'b0}}};
  localparam logic [BKT_W-1:0]  LAST_BKT = BKT_W'(NUM_BUCKETS - 1);

  // wide integers for exact table construction at elaboration
  localparam int BIG_W = 1536;
  typedef logic [BIG_W-1:0] big_t;

  typedef logic [NUM_EDGES-1:0][NS_W-1:0] ns_tab_t;

  // main sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_MUL,
    ST_WALK
  } state_t;

  // target multiplier states
  typedef enum logic [1:0] {
    QM_IDLE,
    QM_RUN,
    QM_FIN
  } qm_state_t;

  // base raised to a power, exact
  function automatic big_t big_pow(input logic [31:0] base, input int e);
    big_t p;
    p = big_t'(1);
    for (int i = 0; i < e; i++) begin
      p = p * big_t'(base);
    end
    return p;
  endfunction

  // edge k is the least integer x with x^BPD >= 10^(LOW_EXP*BPD + k)
  function automatic ns_tab_t build_edge_tab();
    ns_tab_t     tab;
    big_t        t;
    int          est;
    logic        found;
    logic [31:0] x;
    tab = '0;
    t   = big_t'(1);
    for (int i = 0; i < LOW_EXP * BUCKETS_PER_DECADE; i++) begin
      t = t * big_t'(10);
    end
    for (int k = 0; k < NUM_EDGES; k++) begin
      if (k > 0) begin
        t = t * big_t'(10);
      end
      est = $rtoi(10.0 ** (real'(LOW_EXP) + real'(k) * EDGE_STEP));
      found = 1'b0;
      // float estimate lands within one of the exact answer
      for (int j = -1; j <= 2; j++) begin
        x = 32'(est + j);
        if (!found && (big_pow(x, BUCKETS_PER_DECADE) >= t)) begin
          tab[k] = NS_W'(x);
          found  = 1'b1;
        end
      end
    end
    return tab;
  endfunction

  // midpoint k is the least x with (2x+1)^(2BPD) >= 4^BPD * 10^(2*LOW_EXP*BPD + 2k - 1)
  function automatic ns_tab_t build_mid_tab();
    ns_tab_t     tab;
    big_t        t;
    int          est;
    logic        found;
    logic [31:0] x;
    tab = '0;
    t   = big_t'(1) << (2 * BUCKETS_PER_DECADE);
    for (int i = 0; i < 2 * LOW_EXP * BUCKETS_PER_DECADE + 1; i++) begin
      t = t * big_t'(10);
    end
    for (int k = 1; k < NUM_EDGES; k++) begin
      if (k > 1) begin
        t = t * big_t'(100);
      end
      est = $rtoi(10.0 ** (real'(LOW_EXP) + real'(2 * k - 1) * MID_STEP));
      found = 1'b0;
      for (int j = -1; j <= 2; j++) begin
        x = 32'(est + j);
        if (!found && (big_pow(2 * x + 1, 2 * BUCKETS_PER_DECADE) >= t)) begin
          tab[k] = NS_W'(x);
          found  = 1'b1;
        end
      end
    end
    return tab;
  endfunction

  localparam ns_tab_t EDGE_NS = build_edge_tab();
  localparam ns_tab_t MID_NS  = build_mid_tab();

  localparam logic [NS_W-1:0] FIRST_EDGE = EDGE_NS[0];
  localparam logic [NS_W-1:0] LAST_EDGE  = EDGE_NS[NUM_EDGES-1];

endpackage

`default_nettype wire

FILE: sv/llhq_qmul.sv
// ----------------------------------------------------------------------------
// llhq_qmul
// Serial shift-add unit for the quantile target max(1, ceil(q * n / 65536)).
// ----------------------------------------------------------------------------
`default_nettype none

module llhq_qmul #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [COUNT_WIDTH-1:0]            count,
  input  logic [llhq_pkg::FRAC_W-1:0]       frac,
  output logic                              done,
  output logic [COUNT_WIDTH-1:0]            target
);

  localparam int PW    = COUNT_WIDTH + llhq_pkg::FRAC_W;
  localparam int CNT_W = $clog2(llhq_pkg::FRAC_W);

  llhq_pkg::qm_state_t state, state_next;

  logic [PW-1:0]                acc;
  logic [llhq_pkg::FRAC_W-1:0]  mq;
  logic [CNT_W-1:0]             cnt;
  logic [COUNT_WIDTH-1:0]       n_r;
  logic [COUNT_WIDTH:0]         ceil_val;
  logic [COUNT_WIDTH-1:0]       target_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llhq_pkg::QM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      llhq_pkg::QM_IDLE: if (start) state_next = llhq_pkg::QM_RUN;
      llhq_pkg::QM_RUN:  if (cnt == '0) state_next = llhq_pkg::QM_FIN;
      llhq_pkg::QM_FIN:  state_next = llhq_pkg::QM_IDLE;
      default:           state_next = llhq_pkg::QM_IDLE;
    endcase
  end

  // round up the fraction bits, never below one
  always_comb begin
    ceil_val    = acc[PW-1:llhq_pkg::FRAC_SH] +
                  (COUNT_WIDTH+1)'(|acc[llhq_pkg::FRAC_SH-1:0]);
    target_next = (ceil_val == '0) ? COUNT_WIDTH'(1) : ceil_val[COUNT_WIDTH-1:0];
  end

  // msb-first shift-add datapath, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    unique case (state)
      llhq_pkg::QM_IDLE: begin
        if (start) begin
          acc <= '0;
          mq  <= frac;
          n_r <= count;
          cnt <= CNT_W'(llhq_pkg::FRAC_W - 1);
        end
      end
      llhq_pkg::QM_RUN: begin
        acc <= (acc << 1) + (mq[llhq_pkg::FRAC_W-1] ? PW'(n_r) : '0);
        mq  <= mq << 1;
        cnt <= cnt - 1'b1;
      end
      llhq_pkg::QM_FIN: begin
        target <= target_next;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // completion strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == llhq_pkg::QM_FIN);
    end
  end

endmodule

`default_nettype wire

FILE: sv/log_latency_histogram_quantile.sv
// ----------------------------------------------------------------------------
// log_latency_histogram_quantile
// Log-bucketed latency histogram (24 buckets per decade, 100 ns to 1 s, plus
// under- and over-range buckets) with a quantile readout.
//
//   channel   ports                                   handshake
//   command   func, sample_ns, quantile_frac          start high, busy low
//   result    quantile_ns, sample_count               done, one cycle
//
// An add transaction keeps busy high through an 8-step binary search
// over the edge table through one comparator, then a read and a write of the
// bucket memory. A quantile transaction runs a 17-step shift-add target
// multiply, then walks the bucket memory entry by entry behind a
// registered read; busy stays high until the walk reaches the bucket that
// meets the target or the last bucket, and done follows in the next cycle.
// On an empty histogram the result comes the cycle after start and busy stays
// low. Reset clears all buckets at once through per-entry valid bits. Results
// cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module log_latency_histogram_quantile #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                func,
  input  logic [llhq_pkg::SAMPLE_W-1:0]       sample_ns,
  input  logic [llhq_pkg::FRAC_W-1:0]         quantile_frac,
  output logic                                busy,
  output logic                                done,
  output logic [llhq_pkg::NS_W-1:0]           quantile_ns,
  output logic [llhq_pkg::OUT_CNT_W-1:0]      sample_count
);

  localparam int BKT_W  = llhq_pkg::BKT_W;
  localparam int EIDX_W = llhq_pkg::EDGE_IDX_W;

  llhq_pkg::state_t state, state_next;

  logic                              accept;
  logic                              qm_start;
  logic                              qm_done;
  logic [COUNT_WIDTH-1:0]            qm_target;
  logic [llhq_pkg::FRAC_W-1:0]       q_clamp;

  // search
  logic [llhq_pkg::SAMPLE_W-1:0]     sample_r;
  logic [BKT_W-1:0]                  bsel;
  logic [llhq_pkg::BIT_CNT_W-1:0]    bit_cnt;
  logic [BKT_W-1:0]                  cand;
  logic [EIDX_W-1:0]                 e_idx;
  logic                              cand_ok;

  // bucket memory
  logic [COUNT_WIDTH-1:0]            mem [llhq_pkg::NUM_BUCKETS];
  logic [llhq_pkg::NUM_BUCKETS-1:0]  vld;
  logic [BKT_W-1:0]                  rd_addr;
  logic [COUNT_WIDTH-1:0]            rd_data;
  logic                              rd_vld;
  logic [COUNT_WIDTH-1:0]            rd_eff;
  logic [COUNT_WIDTH-1:0]            bump;
  logic [COUNT_WIDTH-1:0]            total_count;

  // walk
  logic [BKT_W-1:0]                  walk_idx;
  logic                              p_vld;
  logic [BKT_W-1:0]                  p_idx;
  logic [COUNT_WIDTH-1:0]            cum;
  logic [COUNT_WIDTH:0]              sum;
  logic [COUNT_WIDTH-1:0]            cum_next;
  logic [COUNT_WIDTH-1:0]            target;
  logic                              hit;
  logic [llhq_pkg::NS_W-1:0]         walk_val;

  // result
  logic                              emit;
  logic [llhq_pkg::NS_W-1:0]         emit_ns;
  logic [llhq_pkg::OUT_CNT_W-1:0]    cnt_out;
  logic [llhq_pkg::NS_W-1:0]         res_ns;
  logic [llhq_pkg::OUT_CNT_W-1:0]    res_cnt;

  assign accept  = start && !busy;
  assign q_clamp = quantile_frac[llhq_pkg::FRAC_W-1] ? llhq_pkg::FRAC_ONE : quantile_frac;

  // target multiplier
  llhq_qmul #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_qmul (
    .clk    (clk),
    .rst    (rst),
    .start  (qm_start),
    .count  (total_count),
    .frac   (q_clamp),
    .done   (qm_done),
    .target (qm_target)
  );

  // one search step: try setting the next bucket bit
  always_comb begin
    cand    = bsel | (BKT_W'(1) << bit_cnt);
    e_idx   = (cand <= BKT_W'(llhq_pkg::NUM_EDGES)) ? EIDX_W'(cand - 1'b1) : '0;
    cand_ok = (cand <= BKT_W'(llhq_pkg::NUM_EDGES)) &&
              (llhq_pkg::SAMPLE_W'(llhq_pkg::EDGE_NS[e_idx]) <= sample_r);
  end

  // memory read data, entries not yet written read as zero
  assign rd_eff  = rd_vld ? rd_data : '0;
  assign bump    = (rd_eff == '1) ? rd_eff : rd_eff + 1'b1;
  assign rd_addr = (state == llhq_pkg::ST_WALK) ? walk_idx : bsel;

  // saturating running sum and the value of the bucket that reaches target
  always_comb begin
    sum      = {1'b0, cum} + {1'b0, rd_eff};
    cum_next = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    hit      = (cum_next >= target);
    if (p_idx == '0) begin
      walk_val = llhq_pkg::FIRST_EDGE;
    end else if (p_idx >= BKT_W'(llhq_pkg::NUM_EDGES)) begin
      walk_val = llhq_pkg::LAST_EDGE;
    end else begin
      walk_val = llhq_pkg::MID_NS[p_idx[EIDX_W-1:0]];
    end
  end

  // reported count, saturated to the port width
  generate
    if (COUNT_WIDTH > llhq_pkg::OUT_CNT_W) begin : g_cnt_sat
      assign cnt_out = (|total_count[COUNT_WIDTH-1:llhq_pkg::OUT_CNT_W]) ?
                       '1 : total_count[llhq_pkg::OUT_CNT_W-1:0];
    end else begin : g_cnt_ext
      assign cnt_out = llhq_pkg::OUT_CNT_W'(total_count);
    end
  endgenerate

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llhq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    busy       = (state != llhq_pkg::ST_IDLE);
    qm_start   = 1'b0;
    emit       = 1'b0;
    emit_ns    = '0;
    unique case (state)
      llhq_pkg::ST_IDLE: begin
        if (start) begin
          if (!func) begin
            state_next = llhq_pkg::ST_SEARCH;
          end else if (total_count == '0) begin
            emit = 1'b1;
          end else begin
            qm_start   = 1'b1;
            state_next = llhq_pkg::ST_MUL;
          end
        end
      end
      llhq_pkg::ST_SEARCH: begin
        if (bit_cnt == '0) state_next = llhq_pkg::ST_ADD_RD;
      end
      llhq_pkg::ST_ADD_RD: begin
        state_next = llhq_pkg::ST_ADD_WR;
      end
      llhq_pkg::ST_ADD_WR: begin
        state_next = llhq_pkg::ST_IDLE;
      end
      llhq_pkg::ST_MUL: begin
        if (qm_done) state_next = llhq_pkg::ST_WALK;
      end
      llhq_pkg::ST_WALK: begin
        if (p_vld && (hit || (p_idx == llhq_pkg::LAST_BKT))) begin
          emit       = 1'b1;
          emit_ns    = hit ? walk_val : llhq_pkg::LAST_EDGE;
          state_next = llhq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = llhq_pkg::ST_IDLE;
      end
    endcase
  end

  // search and walk datapath
  always_ff @(posedge clk) begin
    case (state)
      llhq_pkg::ST_IDLE: begin
        if (accept) begin
          sample_r <= sample_ns;
          bsel     <= '0;
          bit_cnt  <= llhq_pkg::BIT_CNT_W'(BKT_W - 1);
        end
      end
      llhq_pkg::ST_SEARCH: begin
        if (cand_ok) bsel <= cand;
        bit_cnt <= bit_cnt - 1'b1;
      end
      llhq_pkg::ST_MUL: begin
        target   <= qm_target;
        walk_idx <= '0;
        cum      <= '0;
      end
      llhq_pkg::ST_WALK: begin
        walk_idx <= (walk_idx == llhq_pkg::LAST_BKT) ? walk_idx : walk_idx + 1'b1;
        p_idx    <= walk_idx;
        if (p_vld) cum <= cum_next;
      end
      default: begin
        bsel <= bsel;
      end
    endcase
  end

  // walk pipeline valid
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= (state == llhq_pkg::ST_WALK);
    end
  end

  // bucket memory, registered read
  always_ff @(posedge clk) begin
    if (state == llhq_pkg::ST_ADD_WR) begin
      mem[bsel] <= bump;
    end
    rd_data <= mem[rd_addr];
    rd_vld  <= vld[rd_addr];
  end

  // per-entry valid bits and total count
  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      total_count <= '0;
    end else if (state == llhq_pkg::ST_ADD_WR) begin
      vld[bsel]   <= 1'b1;
      total_count <= (total_count == '1) ? total_count : total_count + 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_ns  <= emit_ns;
      res_cnt <= cnt_out;
    end
  end

  assign quantile_ns  = res_ns;
  assign sample_count = res_cnt;

`ifndef SYNTH
  // a result always leaves the sequencer back at idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  // a non-empty histogram never reports zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && (sample_count != '0)) |-> (quantile_ns != '0))
    else $error("zero quantile from non-empty histogram");

  // total count never goes down outside reset
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    ($past(rst) == 1'b0) |-> (total_count >= $past(total_count)))
    else $error("total count decreased");
`endif

endmodule

`default_nettype wire

FILE: bench/log_latency_histogram_quantile_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// log_latency_histogram_quantile_tb
// Self-checking bench for the log-bucketed latency histogram. A directed
// opening covers the empty histogram, the range ends of the samples and the
// quantile extremes. A long random run then mixes adds and queries, with many
// samples placed on and next to the bucket edges. The bench builds its own
// edge and midpoint tables with exact wide-integer powers. It keeps its own
// copy of the bucket counters and predicts every quantile readout.
// ----------------------------------------------------------------------------

module log_latency_histogram_quantile_tb;

  import llhq_pkg::*;

  // command codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 10;
  localparam int NUM_RANDOM   = 1300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 250;
  localparam int CNT_W        = 32;

  // wide enough for (2x+1)^48 with x near 1e9
  localparam int WIDE_W = 1600;
  typedef logic [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic [NS_W-1:0]      quantile_ns;
    logic [OUT_CNT_W-1:0] sample_count;
  } readout_t;

  // --------------------------------------------------------------------------
  // histogram shadow and readout checker
  // --------------------------------------------------------------------------
  class quantile_scoreboard;
    logic [NS_W-1:0]  edge_ns [NUM_EDGES];
    logic [NS_W-1:0]  mid_ns [NUM_EDGES];
    logic [CNT_W-1:0] bucket_counts [NUM_BUCKETS];
    logic [CNT_W-1:0] total_count;
    readout_t         expected_readouts [$];
    int               mismatches;

    function new();
      build_tables();
      foreach (bucket_counts[k]) bucket_counts[k] = '0;
      total_count = '0;
      mismatches  = 0;
    endfunction

    // exact test of base^n >= lim
    function bit power_reaches(logic [31:0] base, int n, wide_t lim);
      wide_t acc;
      acc = wide_t'(1);
      for (int i = 0; i < n; i++) acc = acc * wide_t'(base);
      return acc >= lim;
    endfunction

    // climb from a float guess to the least integer meeting each bound
    function void build_tables();
      wide_t       lim;
      logic [31:0] x;
      lim = wide_t'(1);
      for (int i = 0; i < LOW_EXP * BUCKETS_PER_DECADE; i++) lim = lim * wide_t'(10);
      for (int k = 0; k < NUM_EDGES; k++) begin
        if (k > 0) lim = lim * wide_t'(10);
        x = 32'($rtoi(10.0 ** (real'(LOW_EXP) + real'(k) / real'(BUCKETS_PER_DECADE))));
        if (x < 1) x = 1;
        while (!power_reaches(x, BUCKETS_PER_DECADE, lim)) x = x + 1;
        while (x > 1 && power_reaches(x - 1, BUCKETS_PER_DECADE, lim)) x = x - 1;
        edge_ns[k] = NS_W'(x);
      end
      // midpoints: least x with (2x+1)^(2B) >= 4^B * 10^(2*LOW_EXP*B + 2k - 1)
      mid_ns[0] = '0;
      lim = wide_t'(1) << (2 * BUCKETS_PER_DECADE);
      for (int i = 0; i < 2 * LOW_EXP * BUCKETS_PER_DECADE + 1; i++) lim = lim * wide_t'(10);
      for (int k = 1; k < NUM_EDGES; k++) begin
        if (k > 1) lim = lim * wide_t'(100);
        x = 32'($rtoi(10.0 ** (real'(LOW_EXP) +
                               real'(2 * k - 1) / real'(2 * BUCKETS_PER_DECADE))));
        while (!power_reaches(2 * x + 1, 2 * BUCKETS_PER_DECADE, lim)) x = x + 1;
        while (x > 0 && power_reaches(2 * x - 1, 2 * BUCKETS_PER_DECADE, lim)) x = x - 1;
        mid_ns[k] = NS_W'(x);
      end
    endfunction

    // bucket index is the number of edges at or below the sample
    function int bucket_of(logic [SAMPLE_W-1:0] s);
      int b;
      b = 0;
      for (int k = 0; k < NUM_EDGES; k++) begin
        if ({2'b00, edge_ns[k]} <= s) b = k + 1;
      end
      return b;
    endfunction

    function readout_t predict_quantile(logic [FRAC_W-1:0] frac);
      logic [63:0] q;
      logic [63:0] n;
      logic [63:0] target;
      logic [63:0] cum;
      bit          found;
      readout_t    r;
      q = 64'(frac);
      if (q > 64'(FRAC_ONE)) q = 64'(FRAC_ONE);
      n = 64'(total_count);
      r.quantile_ns  = '0;
      r.sample_count = OUT_CNT_W'(total_count);
      if (n != 0) begin
        // target is ceil(q * n / 65536), at least one
        if (q == 64'(FRAC_ONE)) begin
          target = n;
        end else begin
          target = q * (n >> 16) + ((q * (n & 64'hFFFF) + 64'hFFFF) >> 16);
        end
        if (target == 0) target = 1;
        r.quantile_ns = edge_ns[NUM_EDGES-1];
        cum   = '0;
        found = 1'b0;
        for (int k = 0; k < NUM_BUCKETS; k++) begin
          if (!found) begin
            cum = cum + 64'(bucket_counts[k]);
            if (cum >= target) begin
              found = 1'b1;
              if (k == 0) begin
                r.quantile_ns = edge_ns[0];
              end else if (k >= NUM_EDGES) begin
                r.quantile_ns = edge_ns[NUM_EDGES-1];
              end else begin
                r.quantile_ns = mid_ns[k];
              end
            end
          end
        end
      end
      return r;
    endfunction

    // note an accepted command transaction
    function void record_command(logic f, logic [SAMPLE_W-1:0] s, logic [FRAC_W-1:0] frac);
      int b;
      if (f == FUNC_QUERY) begin
        expected_readouts.insert(expected_readouts.size(), predict_quantile(frac));
      end else begin
        b = bucket_of(s);
        if (bucket_counts[b] != '1) bucket_counts[b] = bucket_counts[b] + 1;
        if (total_count != '1) total_count = total_count + 1;
      end
    endfunction

    // compare a result transaction with the oldest expectation
    function void check_readout(logic [NS_W-1:0] qns, logic [OUT_CNT_W-1:0] cnt);
      readout_t want;
      if (expected_readouts.size() == 0) begin
        $error("unexpected readout: quantile_ns=%0d sample_count=%0d", qns, cnt);
        mismatches++;
      end else begin
        want = expected_readouts.pop_front();
        if (qns !== want.quantile_ns) begin
          $error("quantile_ns: expected %0d, got %0d", want.quantile_ns, qns);
          mismatches++;
        end
        if (cnt !== want.sample_count) begin
          $error("sample_count: expected %0d, got %0d", want.sample_count, cnt);
          mismatches++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 start         = 1'b0;
  logic                 func          = FUNC_ADD;
  logic [SAMPLE_W-1:0]  sample_ns     = '0;
  logic [FRAC_W-1:0]    quantile_frac = '0;
  logic                 busy;
  logic                 done;
  logic [NS_W-1:0]      quantile_ns;
  logic [OUT_CNT_W-1:0] sample_count;

  quantile_scoreboard sb;
  int                 idle_cycles = 0;

  log_latency_histogram_quantile #(
    .COUNT_WIDTH (CNT_W)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .func          (func),
    .sample_ns     (sample_ns),
    .quantile_frac (quantile_frac),
    .busy          (busy),
    .done          (done),
    .quantile_ns   (quantile_ns),
    .sample_count  (sample_count)
  );

  // clock
  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // score each transaction at the clock edge, results before new commands
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_readout(quantile_ns, sample_count);
      if (start && !busy) sb.record_command(func, sample_ns, quantile_frac);
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------
  task automatic send_command(input logic f, input logic [SAMPLE_W-1:0] s,
                              input logic [FRAC_W-1:0] q);
    @(negedge clk);
    start         <= 1'b1;
    func          <= f;
    sample_ns     <= s;
    quantile_frac <= q;
    do @(posedge clk); while (busy);
  endtask

  // unused field carries noise
  task automatic send_add(input logic [SAMPLE_W-1:0] s);
    send_command(FUNC_ADD, s, FRAC_W'($urandom));
  endtask

  task automatic send_query(input logic [FRAC_W-1:0] q);
    send_command(FUNC_QUERY, $urandom, q);
  endtask

  // sender gap with garbage on the idle bus
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start         <= 1'b0;
      func          <= 1'($urandom);
      sample_ns     <= $urandom;
      quantile_frac <= FRAC_W'($urandom);
    end
  endtask

  // pause until every pending readout has arrived
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_readouts.size() != 0) @(posedge clk);
  endtask

  // samples biased toward bucket edges and typical latencies
  function automatic logic [SAMPLE_W-1:0] random_sample();
    int pick;
    int k;
    pick = $urandom_range(0, 9);
    k    = $urandom_range(0, NUM_EDGES - 1);
    case (pick)
      0, 1, 2, 3: return SAMPLE_W'(sb.edge_ns[k]) + SAMPLE_W'($urandom_range(0, 2)) - 1;
      4, 5:       return $urandom >> $urandom_range(0, 31);
      6:          return $urandom;
      7:          return SAMPLE_W'($urandom_range(0, 200));
      default:    return SAMPLE_W'($urandom_range(1000, 10_000_000));
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] random_frac();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3:    return FRAC_W'($urandom_range(0, (1 << FRAC_W) - 1));
      4, 5, 6, 7:    return FRAC_W'($urandom_range(0, 32'(FRAC_ONE)));
      8:             return FRAC_W'($urandom_range(0, 16));
      default:       return FRAC_W'($urandom_range(32'(FRAC_ONE) - 16, 32'(FRAC_ONE) + 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int issued;
    int burst;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty histogram, back to back
    send_query('0);
    send_query(FRAC_ONE);
    send_query('1);

    // range ends and bucket boundaries
    send_add('0);
    send_add(99);
    send_add(100);
    send_add(101);
    send_add(999_999_999);
    send_add(1_000_000_000);
    send_add('1);
    send_add(32'h5555_5555);
    send_add(32'hAAAA_AAAA);
    send_add(12_345);

    // quantile extremes, including clamp above one
    send_query('0);
    send_query(1);
    send_query(FRAC_ONE >> 1);
    send_query(FRAC_ONE - 1);
    send_query(FRAC_ONE);
    send_query(FRAC_ONE + 1);
    send_query('1);
    drain_results();

    // random bursts, with one full drain halfway
    issued = 0;
    while (issued < NUM_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && issued < NUM_RANDOM; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_query(random_frac());
        end else begin
          send_add(random_sample());
        end
        issued++;
        if (issued == NUM_RANDOM / 2) drain_results();
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 15));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_readouts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
